FILE: rtl/bole_pkg.sv
package bole_pkg;

   localparam int CAPACITY    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int IN_VALUE_W  = 32;
   localparam int OP_W        = 3;
   localparam int POS_W       = 4;
   localparam int REMOVED_W   = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int IDX_W       = $clog2(CAPACITY);

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_INSERT     = 3'd1;
   localparam op_type OP_DELETE     = 3'd2;
   localparam op_type OP_SEARCH     = 3'd3;
   localparam op_type OP_CLEAR      = 3'd4;

   typedef struct packed {
      logic load;
      logic insert;
      logic remove;
      logic clear;
      logic publish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   any_match;
   } stat_type;

endpackage

FILE: rtl/bole_req_if.sv
interface bole_req_if import bole_pkg::*; ();
   logic                         valid;
   logic                         ready;
   op_type                       op;
   logic signed [IN_VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

FILE: rtl/bole_rsp_if.sv
interface bole_rsp_if import bole_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic                   found;
   logic [POS_W-1:0]       first_position;
   logic [REMOVED_W-1:0]   removed;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output found, output first_position,
                   output removed, output entry_count, input ready);
   modport sink (input valid, input status, input found, input first_position,
                 input removed, input entry_count, output ready);
endinterface

FILE: rtl/bole_dpath.sv
module bole_dpath import bole_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  op_type                       req_op,
   input  logic signed [IN_VALUE_W-1:0] req_value,
   output stat_type                     stat,
   output logic                         rsp_status,
   output logic                         rsp_found,
   output logic [POS_W-1:0]             rsp_first_position,
   output logic [REMOVED_W-1:0]         rsp_removed,
   output logic [COUNT_OUT_W-1:0]       rsp_entry_count
);

   op_type                       op_ff;
   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] entries_ff [CAPACITY];
   logic signed [VALUE_BITS-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic [CNT_W-1:0]             removed_ff;
   logic [CNT_W-1:0]             removed_in;
   logic [CAPACITY-1:0]          eq_vec;
   logic [CAPACITY-1:0]          ge_vec;
   logic [IDX_W-1:0]             match_pos;
   logic [IDX_W-1:0]             ge_pos;
   logic [IDX_W-1:0]             ins_pos;
   logic                         any_ge;
   logic                         full;
   logic                         is_add;

   logic                         rsp_status_ff;
   logic                         rsp_found_ff;
   logic [POS_W-1:0]             rsp_first_position_ff;
   logic [REMOVED_W-1:0]         rsp_removed_ff;
   logic [COUNT_OUT_W-1:0]       rsp_entry_count_ff;

   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign is_add = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_INSERT);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         eq_vec[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == value_ff);
         ge_vec[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] >= value_ff);
      end
   end

   // first set position, lowest index wins
   always_comb begin
      match_pos = '0;
      ge_pos    = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (eq_vec[i]) begin
            match_pos = IDX_W'(i);
         end
         if (ge_vec[i]) begin
            ge_pos = IDX_W'(i);
         end
      end
   end

   assign any_ge = |ge_vec;

   always_comb begin
      if (op_ff == OP_PUSH_FRONT) begin
         ins_pos = '0;
      end else if (any_ge) begin
         ins_pos = ge_pos;
      end else begin
         ins_pos = count_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
      end
      count_in   = count_ff;
      removed_in = removed_ff;
      if (cmd.insert) begin
         if (ins_pos == '0) begin
            entries_in[0] = value_ff;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (IDX_W'(i) > ins_pos) begin
               entries_in[i] = entries_ff[i-1];
            end else if (IDX_W'(i) == ins_pos) begin
               entries_in[i] = value_ff;
            end
         end
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= match_pos) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
         count_in   = count_ff - CNT_W'(1);
         removed_in = removed_ff + CNT_W'(1);
      end else if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.load) begin
         removed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      removed_ff <= removed_in;
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= VALUE_BITS'(req_value);
      end
      if (cmd.publish) begin
         rsp_status_ff         <= is_add && full;
         rsp_found_ff          <= (op_ff == OP_SEARCH) && (|eq_vec);
         rsp_first_position_ff <= ((op_ff == OP_SEARCH) && (|eq_vec)) ?
                                  POS_W'(match_pos) : '0;
         rsp_removed_ff        <= (op_ff == OP_DELETE) ? REMOVED_W'(removed_ff) : '0;
         rsp_entry_count_ff    <= COUNT_OUT_W'(count_in);
      end
   end

   assign stat.op             = op_ff;
   assign stat.full           = full;
   assign stat.any_match      = |eq_vec;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_first_position  = rsp_first_position_ff;
   assign rsp_removed         = rsp_removed_ff;
   assign rsp_entry_count     = rsp_entry_count_ff;

endmodule

FILE: rtl/bole_ctrl.sv
module bole_ctrl import bole_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((stat.op == OP_DELETE) && stat.any_match) begin
               cmd.remove = 1'b1;
            end else if (slot_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               case (stat.op)
                  OP_PUSH_FRONT, OP_INSERT: cmd.insert = !stat.full;
                  OP_CLEAR:                 cmd.clear  = 1'b1;
                  default:                  cmd.insert = 1'b0;
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/bounded_ordered_list_engine_core.sv
// An item is loaded on accept; its result is registered when the controller publishes it from
// the execute state, after a delete has removed its matching entries one by one. A new item is
// taken only once the last is published; a pending result only stalls execution, not its own delivery.
// Reset: synchronous, active high; clears the entry count and pending result, list is empty.
// Entry contents are not cleared; only positions below the count are ever read.
module bounded_ordered_list_engine_core import bole_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bole_req_if.sink   req_chan,
   bole_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bole_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_op             (req_chan.op),
      .req_value          (req_chan.value),
      .stat               (stat),
      .rsp_status         (rsp_chan.status),
      .rsp_found          (rsp_chan.found),
      .rsp_first_position (rsp_chan.first_position),
      .rsp_removed        (rsp_chan.removed),
      .rsp_entry_count    (rsp_chan.entry_count)
   );

endmodule
